// ----- hw/rtl/multivoice_sample_mixer_unit_assert.svh -----
// assertion helpers for the sample mixer, clocked on clk, off during reset
`ifndef MULTIVOICE_SAMPLE_MIXER_UNIT_ASSERT_SVH
`define MULTIVOICE_SAMPLE_MIXER_UNIT_ASSERT_SVH

// same-cycle implication
`define MSM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mixer check failed");

// next-cycle implication
`define MSM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mixer check failed");

`endif

// ----- hw/rtl/msm_pkg.sv -----
package msm_pkg;

	// sizing
	localparam int VOICES    = 16;
	localparam int ADDR_BITS = 16;
	localparam int VIDX_W    = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SUM_W     = (ADDR_BITS > 17) ? ADDR_BITS : 17;
	localparam int APB_ADDR_W = 3;

	// stored byte is raw byte minus this, modulo 256
	localparam logic [7:0] LOAD_OFFSET = 8'd127;

	// command codes
	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	// status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_STARTED = 2'd1;
	localparam logic [1:0] ST_DROPPED = 2'd2;
	localparam logic [1:0] ST_IGNORED = 2'd3;

	// register indexes
	localparam logic [APB_ADDR_W-3:0] REG_OUTPUT_ENABLE = '0;

	// sample memory request from the sequencer
	typedef struct packed {
		logic                 we;
		logic [ADDR_BITS-1:0] waddr;
		logic [7:0]           wdata;
		logic                 re;
		logic [ADDR_BITS-1:0] raddr;
	} ram_req_t;

endpackage

// ----- hw/rtl/msm_if.sv -----
// command item channel
interface msm_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [15:0] address;
	logic [7:0]  byte_value;
	logic [15:0] length;
	logic        loop_play;

	modport source (output valid, command, address, byte_value, length, loop_play,
		input ready);
	modport sink (input valid, command, address, byte_value, length, loop_play,
		output ready);
endinterface

// result item channel
interface msm_res_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] mixed_sample;
	logic              sample_valid;
	logic [1:0]        status;
	logic [3:0]        voice_index;

	modport source (output valid, mixed_sample, sample_valid, status, voice_index,
		input ready);
	modport sink (input valid, mixed_sample, sample_valid, status, voice_index,
		output ready);
endinterface

// ----- hw/rtl/msm_sample_ram.sv -----
module msm_sample_ram (
	input  logic              clk,
	input  msm_pkg::ram_req_t req,
	output logic [7:0]        rdata
);
	import msm_pkg::*;

	logic [7:0] mem [2**ADDR_BITS];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

// ----- hw/rtl/msm_mixer_core.sv -----
module msm_mixer_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              output_enable,
	msm_cmd_if.sink           cmd_ch,
	msm_res_if.source         res_ch,
	output msm_pkg::ram_req_t ram_req,
	input  logic [7:0]        ram_rdata
);
	import msm_pkg::*;
	`include "multivoice_sample_mixer_unit_assert.svh"

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_START = 3'd1;
	localparam logic [2:0] S_TICK  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	localparam logic [VIDX_W-1:0] IDX_TOP = VIDX_W'(VOICES - 1);

	logic [2:0]        state_q;
	logic [VIDX_W-1:0] idx_q;
	logic [VOICES-1:0] active_q;
	logic [VOICES-1:0] loop_q;
	logic [15:0]       base_q [VOICES];
	logic [15:0]       len_q  [VOICES];
	logic [15:0]       pos_q  [VOICES];
	logic              acc_s1;
	logic [7:0]        sum_q;
	logic              out_valid_q;

	// start request held while the free voice is searched
	logic [15:0] st_base_q;
	logic [15:0] st_len_q;
	logic        st_loop_q;

	// pending result
	logic        res_tick_q;
	logic [1:0]  res_status_q;
	logic [3:0]  res_voice_q;

	// result output register
	logic [7:0] out_mix_q;
	logic       out_sv_q;
	logic [1:0] out_status_q;
	logic [3:0] out_voice_q;

	logic             in_fire;
	logic             cur_act;
	logic             cur_wrap;
	logic             cur_keep;
	logic [15:0]      pos_eff;
	logic [SUM_W-1:0] addr_sum;
	logic             issue;
	logic             fin_go;

	assign in_fire      = cmd_ch.valid && cmd_ch.ready;
	assign cmd_ch.ready = (state_q == S_IDLE);

	// per-voice step of the tick: end check, rewind, address add
	always_comb begin
		cur_act  = active_q[idx_q];
		cur_wrap = pos_q[idx_q] >= len_q[idx_q];
		cur_keep = !cur_wrap || loop_q[idx_q];
		pos_eff  = cur_wrap ? 16'd0 : pos_q[idx_q];
		addr_sum = SUM_W'(base_q[idx_q]) + SUM_W'(pos_eff);
		issue    = (state_q == S_TICK) && cur_act && cur_keep;
	end

	// sample memory request
	always_comb begin
		ram_req.we    = in_fire && (cmd_ch.command == CMD_LOAD);
		ram_req.waddr = ADDR_BITS'(cmd_ch.address);
		ram_req.wdata = cmd_ch.byte_value - LOAD_OFFSET;
		ram_req.re    = issue;
		ram_req.raddr = addr_sum[ADDR_BITS-1:0];
	end

	assign fin_go = (state_q == S_FIN) && (!out_valid_q || res_ch.ready);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			active_q    <= '0;
			acc_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			acc_s1 <= issue;
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						idx_q <= IDX_TOP;
						unique case (cmd_ch.command)
							CMD_LOAD: state_q <= S_FIN;
							CMD_START: state_q <= (cmd_ch.length == 16'd0) ? S_FIN : S_START;
							CMD_CLEAR: begin
								active_q <= '0;
								state_q  <= S_FIN;
							end
							CMD_TICK: state_q <= output_enable ? S_TICK : S_FIN;
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_START: begin
					if (!active_q[idx_q]) begin
						active_q[idx_q] <= 1'b1;
						state_q         <= S_FIN;
					end else if (idx_q == '0) begin
						state_q <= S_FIN;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				S_TICK: begin
					if (cur_act && !cur_keep) begin
						active_q[idx_q] <= 1'b0;
					end
					if (idx_q == '0) begin
						state_q <= S_DRAIN;
					end else begin
						idx_q <= idx_q - 1'b1;
					end
				end
				S_DRAIN: state_q <= S_FIN;
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// output handshake
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (res_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// voice table, accumulator and result payload
	always_ff @(posedge clk) begin
		if (acc_s1) begin
			sum_q <= sum_q + ram_rdata;
		end
		if (in_fire) begin
			st_base_q    <= cmd_ch.address;
			st_len_q     <= cmd_ch.length;
			st_loop_q    <= cmd_ch.loop_play;
			sum_q        <= 8'd0;
			res_tick_q   <= (cmd_ch.command == CMD_TICK) && output_enable;
			res_voice_q  <= 4'd0;
			res_status_q <= ((cmd_ch.command == CMD_START) && (cmd_ch.length == 16'd0))
				? ST_IGNORED : ST_DONE;
		end
		if (state_q == S_START) begin
			if (!active_q[idx_q]) begin
				base_q[idx_q] <= st_base_q;
				len_q[idx_q]  <= st_len_q;
				loop_q[idx_q] <= st_loop_q;
				pos_q[idx_q]  <= 16'd0;
				res_status_q  <= ST_STARTED;
				res_voice_q   <= 4'(idx_q);
			end else if (idx_q == '0) begin
				res_status_q <= ST_DROPPED;
			end
		end
		if (issue) begin
			pos_q[idx_q] <= pos_eff + 16'd1;
		end
		if (fin_go) begin
			out_mix_q    <= res_tick_q ? sum_q : 8'd0;
			out_sv_q     <= res_tick_q;
			out_status_q <= res_status_q;
			out_voice_q  <= res_voice_q;
		end
	end

	assign res_ch.valid        = out_valid_q;
	assign res_ch.mixed_sample = $signed(out_mix_q);
	assign res_ch.sample_valid = out_sv_q;
	assign res_ch.status       = out_status_q;
	assign res_ch.voice_index  = out_voice_q;

	`MSM_ASSERT_NEXT(a_busy_after_accept, in_fire, state_q != S_IDLE)
	`MSM_ASSERT_NOW(a_acc_in_tick, acc_s1, state_q == S_TICK || state_q == S_DRAIN)
	`MSM_ASSERT_NOW(a_write_only_idle, ram_req.we, state_q == S_IDLE)
	`MSM_ASSERT_NEXT(a_drain_to_fin, state_q == S_DRAIN, state_q == S_FIN)

endmodule

// ----- hw/rtl/multivoice_sample_mixer_unit.sv -----
// load, clear, zero-length start and disabled tick go from idle straight to the result state
// other start: one voice checked per cycle from the highest down until a free one is found
// enabled tick: one sample memory read per active voice that is still playing, then a drain state
// one item at a time; the next item is taken the cycle after its result is registered,
// even while that result waits
// reset clears all voices and sets output_enable; sample memory is not cleared
module multivoice_sample_mixer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [msm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	msm_cmd_if.sink                        cmd_ch,
	msm_res_if.source                      res_ch
);
	import msm_pkg::*;

	logic              output_enable_q;
	logic              cfg_write;
	logic [APB_ADDR_W-3:0] reg_index;
	ram_req_t          ram_req;
	logic [7:0]        ram_rdata;

	assign pready    = 1'b1;
	assign reg_index = paddr[APB_ADDR_W-1:2];
	assign cfg_write = psel && penable && pwrite && pready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_enable_q <= 1'b1;
		end else if (cfg_write && (reg_index == REG_OUTPUT_ENABLE)) begin
			output_enable_q <= pwdata[0];
		end
	end

	// register readback
	always_comb begin
		prdata = 32'd0;
		if (reg_index == REG_OUTPUT_ENABLE) begin
			prdata = {31'd0, output_enable_q};
		end
	end

	msm_mixer_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.output_enable (output_enable_q),
		.cmd_ch        (cmd_ch),
		.res_ch        (res_ch),
		.ram_req       (ram_req),
		.ram_rdata     (ram_rdata)
	);

	msm_sample_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

endmodule

// ----- bench/multivoice_sample_mixer_unit_tb.sv -----
`timescale 1ns / 100ps

module multivoice_sample_mixer_unit_tb;
	import msm_pkg::*;

	localparam int HALF_PERIOD   = 6;
	localparam int RESET_CYCLES  = 12;
	localparam int IDLE_PCT      = 28;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 30;
	localparam int QUIET_LIMIT   = 2500;
	localparam int WINDOW        = 512;
	localparam logic [APB_ADDR_W-1:0] ENABLE_ADDR = {REG_OUTPUT_ENABLE, 2'b00};

	typedef struct {
		logic [1:0]  command;
		logic [15:0] address;
		logic [7:0]  byte_value;
		logic [15:0] length;
		logic        loop_play;
	} mix_cmd_t;

	typedef struct {
		logic signed [7:0] mixed_sample;
		logic              sample_valid;
		logic [1:0]        status;
		logic [3:0]        voice_index;
	} mix_res_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	msm_cmd_if cmd_bus ();
	msm_res_if result_bus ();

	multivoice_sample_mixer_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cmd_ch  (cmd_bus),
		.res_ch  (result_bus)
	);

	// mirror of the mixer state
	logic [7:0]  stored_bytes [int];
	logic        voice_on [VOICES];
	logic        voice_rep [VOICES];
	logic [15:0] voice_base_addr [VOICES];
	logic [15:0] voice_len [VOICES];
	logic [15:0] voice_pos [VOICES];
	logic        out_en;

	mix_res_t pending_results [$];
	int       errors;
	int       quiet_cycles;
	bit       no_idle;
	bit       hold_req;

	// clock
	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	function automatic void mirror_reset();
		stored_bytes.delete();
		for (int i = 0; i < VOICES; i++) begin
			voice_on[i] = 1'b0;
			voice_rep[i] = 1'b0;
			voice_base_addr[i] = '0;
			voice_len[i] = '0;
			voice_pos[i] = '0;
		end
		out_en = 1'b1;
	endfunction

	// next mixer output for one command, updating the mirror
	function automatic mix_res_t mix_predict(input mix_cmd_t c);
		mix_res_t r;
		logic [7:0] acc;
		logic [15:0] a;
		bit placed;
		r.mixed_sample = '0;
		r.sample_valid = 1'b0;
		r.status = ST_DONE;
		r.voice_index = '0;
		case (c.command)
			CMD_LOAD: begin
				stored_bytes[int'(c.address)] = c.byte_value - LOAD_OFFSET;
			end
			CMD_START: begin
				if (c.length == 16'd0) begin
					r.status = ST_IGNORED;
				end else begin
					r.status = ST_DROPPED;
					placed = 1'b0;
					// highest free voice wins
					for (int i = VOICES - 1; i >= 0 && !placed; i--) begin
						if (!voice_on[i]) begin
							voice_on[i] = 1'b1;
							voice_rep[i] = c.loop_play;
							voice_base_addr[i] = c.address;
							voice_len[i] = c.length;
							voice_pos[i] = '0;
							r.status = ST_STARTED;
							r.voice_index = 4'(i);
							placed = 1'b1;
						end
					end
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < VOICES; i++)
					voice_on[i] = 1'b0;
			end
			default: begin
				if (out_en) begin
					acc = '0;
					for (int i = VOICES - 1; i >= 0; i--) begin
						if (!voice_on[i])
							continue;
						// end of sound: rewind or free
						if (voice_pos[i] >= voice_len[i]) begin
							if (voice_rep[i]) begin
								voice_pos[i] = '0;
							end else begin
								voice_on[i] = 1'b0;
								continue;
							end
						end
						a = voice_base_addr[i] + voice_pos[i];
						acc = acc + stored_bytes[int'(a)];
						voice_pos[i] = voice_pos[i] + 16'd1;
					end
					r.mixed_sample = acc;
					r.sample_valid = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// random content in every field, the command decides which matter
	function automatic mix_cmd_t noise_item();
		mix_cmd_t c;
		c.command = 2'($urandom);
		c.address = 16'($urandom);
		c.byte_value = 8'($urandom);
		c.length = 16'($urandom);
		c.loop_play = 1'($urandom);
		return c;
	endfunction

	// offer one command item and record what it should produce
	task automatic send_item(input mix_cmd_t c);
		@(negedge clk);
		while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			cmd_bus.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.command <= c.command;
		cmd_bus.address <= c.address;
		cmd_bus.byte_value <= c.byte_value;
		cmd_bus.length <= c.length;
		cmd_bus.loop_play <= c.loop_play;
		do @(posedge clk); while (!cmd_bus.ready);
		pending_results.push_back(mix_predict(c));
	endtask

	task automatic release_bus();
		@(negedge clk);
		cmd_bus.valid <= 1'b0;
	endtask

	task automatic send_load(input logic [15:0] addr);
		mix_cmd_t c;
		c = noise_item();
		c.command = CMD_LOAD;
		c.address = addr;
		send_item(c);
	endtask

	task automatic send_start(input logic [15:0] base, input logic [15:0] len, input logic lp);
		mix_cmd_t c;
		c = noise_item();
		c.command = CMD_START;
		c.address = base;
		c.length = len;
		c.loop_play = lp;
		send_item(c);
	endtask

	task automatic send_clear();
		mix_cmd_t c;
		c = noise_item();
		c.command = CMD_CLEAR;
		send_item(c);
	endtask

	// tick, first loading any byte a voice is about to read that was never written
	task automatic tick_voices();
		mix_cmd_t c;
		logic [15:0] a;
		if (out_en) begin
			for (int i = VOICES - 1; i >= 0; i--) begin
				if (!voice_on[i])
					continue;
				if (voice_pos[i] >= voice_len[i]) begin
					if (!voice_rep[i])
						continue;
					a = voice_base_addr[i];
				end else begin
					a = voice_base_addr[i] + voice_pos[i];
				end
				if (!stored_bytes.exists(int'(a)))
					send_load(a);
			end
		end
		c = noise_item();
		c.command = CMD_TICK;
		send_item(c);
	endtask

	// register write and read back, only with the mixer idle
	task automatic set_enable(input logic en);
		logic [31:0] rd;
		release_bus();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ENABLE_ADDR;
		pwdata <= {31'd0, en};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		out_en = en;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[0] !== en) begin
			$error("output_enable expected %0d got %0d", en, rd[0]);
			errors++;
		end
	endtask

	task automatic random_action();
		int pick;
		logic [15:0] a;
		logic [15:0] len;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			a = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, WINDOW - 1));
			send_load(a);
		end else if (pick < 55) begin
			a = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, WINDOW - 1));
			case ($urandom_range(0, 19))
				0: len = 16'd0;
				1: len = 16'($urandom);
				default: len = 16'($urandom_range(1, 48));
			endcase
			send_start(a, len, 1'($urandom));
		end else if (pick < 95) begin
			tick_voices();
		end else begin
			send_clear();
		end
	endtask

	// extremes of load address and byte
	task automatic test_load_extremes();
		mix_cmd_t c;
		c = noise_item();
		c.command = CMD_LOAD;
		c.address = 16'h0000;
		c.byte_value = 8'h00;
		send_item(c);
		c.address = 16'hFFFF;
		c.byte_value = 8'hFF;
		send_item(c);
	endtask

	// zero length, looping voice across the address wrap, one-shot voice freed
	task automatic test_voice_end();
		send_start(16'h1234, 16'd0, 1'b1);
		send_start(16'hFFFF, 16'd2, 1'b1);
		send_start(16'h0000, 16'd1, 1'b0);
		repeat (3) tick_voices();
	endtask

	// tick with output disabled leaves everything alone
	task automatic test_output_disable();
		set_enable(1'b0);
		tick_voices();
		set_enable(1'b1);
	endtask

	// all voices taken, then a start is dropped
	task automatic test_voice_exhaustion();
		send_clear();
		send_start(16'h0000, 16'hFFFF, 1'b1);
		for (int i = 1; i < VOICES; i++)
			send_start(16'($urandom_range(0, 3)), 16'($urandom_range(1, 4)), 1'($urandom));
		send_start(16'($urandom), 16'($urandom_range(1, 65535)), 1'($urandom));
		tick_voices();
		send_clear();
	endtask

	task automatic test_random_mix(input int n);
		repeat (n) random_action();
	endtask

	// receiver holds off while commands keep coming
	task automatic test_backpressure();
		hold_req = 1'b1;
		repeat (16) random_action();
	endtask

	task automatic test_burst(input int n);
		no_idle = 1'b1;
		repeat (n) random_action();
		no_idle = 1'b0;
	endtask

	// result side ready, with idling and one long hold-off
	initial begin
		result_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				repeat (HOLD_CYCLES) begin
					result_bus.ready <= 1'b0;
					@(negedge clk);
				end
			end
			result_bus.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// compare each result item with the oldest expectation
	always @(posedge clk) begin
		mix_res_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_results.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (result_bus.mixed_sample !== want.mixed_sample) begin
					$error("mixed_sample expected %0d got %0d", want.mixed_sample,
						result_bus.mixed_sample);
					errors++;
				end
				if (result_bus.sample_valid !== want.sample_valid) begin
					$error("sample_valid expected %0d got %0d", want.sample_valid,
						result_bus.sample_valid);
					errors++;
				end
				if (result_bus.status !== want.status) begin
					$error("status expected %0d got %0d", want.status, result_bus.status);
					errors++;
				end
				if (result_bus.voice_index !== want.voice_index) begin
					$error("voice_index expected %0d got %0d", want.voice_index,
						result_bus.voice_index);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (result_bus.valid && result_bus.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("multivoice_sample_mixer_unit verification failed");
			$finish;
		end
	end

	// test sequence
	initial begin
		errors = 0;
		quiet_cycles = 0;
		no_idle = 1'b0;
		hold_req = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_bus.valid = 1'b0;
		cmd_bus.command = CMD_LOAD;
		cmd_bus.address = '0;
		cmd_bus.byte_value = '0;
		cmd_bus.length = '0;
		cmd_bus.loop_play = 1'b0;
		mirror_reset();
		arst_n = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// random actions also pull in loads for bytes that ticks are about to read
		test_load_extremes();
		test_voice_end();
		test_output_disable();
		test_voice_exhaustion();
		test_random_mix(180);
		test_backpressure();
		set_enable(1'b0);
		test_random_mix(30);
		set_enable(1'b1);
		test_burst(100);
		test_random_mix(200);

		// drain
		release_bus();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("multivoice_sample_mixer_unit verification clean");
		else
			$display("multivoice_sample_mixer_unit verification failed");
		$finish;
	end

endmodule
